@@ design/rfsc_pkg.sv @@
// ----------------------------------------------------------------------------
// rfsc_pkg
// Shared types and constants of the remote frame sync channel decoder.
// ----------------------------------------------------------------------------
package rfsc_pkg;

   localparam int FRAME_BYTES  = 34;
   localparam int WINDOW_CELLS = FRAME_BYTES - 1;
   localparam int COUNT_W      = 6;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [COUNT_W-1:0] COUNT_FULL    = COUNT_W'(FRAME_BYTES);
   localparam logic [COUNT_W-1:0] COUNT_PRE_END = COUNT_W'(FRAME_BYTES - 1);

   localparam logic [7:0] HEADER_RESET  = 8'h0f;
   localparam logic [7:0] TRAILER_RESET = 8'h00;

   localparam logic REG_HEADER  = 1'b0;
   localparam logic REG_TRAILER = 1'b1;

   // Scaling (raw - 992) * 100 / 820 reduces to (raw - 992) * 5 / 41.
   // The division by 41 is a multiply by ceil(2^25 / 41) and a shift,
   // exact for every magnitude below 2^19.
   localparam logic signed [17:0] RAW_CENTER  = 18'sd992;
   localparam logic [19:0]        RECIP_MUL   = 20'd818401;
   localparam int                 RECIP_SHIFT = 25;

   typedef struct packed {
      logic [3:0] index;
      logic       last;
   } rfsc_tag_type;

endpackage

@@ design/remote_frame_sync_channel_decode_unit.sv @@
// ----------------------------------------------------------------------------
// remote_frame_sync_channel_decode_unit
// Frame sync and channel decoder for a remote-control serial byte stream.
// ----------------------------------------------------------------------------
// Received bytes arrive on the req_ channel, one byte per transfer, and may
// come in every cycle. They shift through a row of byte cells that hold the
// last 33 bytes. When 34 bytes have arrived since reset or the last frame,
// the oldest byte equals the header register and the incoming byte equals
// the trailer register, the channel pairs are copied into a channel queue.
// The queue then sends one channel per cycle through a two-stage scaler and
// the output register, so the rsp_ channel carries CHANNELS transfers per
// frame, the last one flagged. A stall on rsp_ freezes the scaler and the
// queue. While the queue still drains, req_stall rises only when the next
// byte could complete a frame. Reset clears the fresh byte count, the
// pipeline and the queue, and loads header 0x0f and trailer 0x00. Registers
// sit at csr_ byte address 0 and 4.
// ----------------------------------------------------------------------------
module remote_frame_sync_channel_decode_unit #(
   parameter int CHANNELS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [3:0]                         rsp_channel_index,
   output logic signed [13:0]                 rsp_channel_value,
   output logic                               rsp_last_channel,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rfsc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rfsc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rfsc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import rfsc_pkg::*;

   logic [7:0]         header_ff;
   logic [7:0]         trailer_ff;
   logic               csr_write;

   logic [7:0]         win_byte [WINDOW_CELLS];
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               req_take;
   logic               frame_match;

   logic [15:0]        chan_ff [CHANNELS];
   logic               busy_ff;
   logic [3:0]         emit_idx_ff;
   logic               advance;
   logic               push;
   rfsc_tag_type       push_tag;

   logic               sc_valid;
   logic               sc_neg;
   logic [13:0]        sc_quot;
   rfsc_tag_type       sc_tag;

   logic               rsp_valid_ff;
   logic [3:0]         rsp_index_ff;
   logic signed [13:0] rsp_value_ff;
   logic               rsp_last_ff;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_TRAILER) ? CSR_DATA_W'(trailer_ff)
                                                     : CSR_DATA_W'(header_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= HEADER_RESET;
         trailer_ff <= TRAILER_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_HEADER:  header_ff  <= csr_pwdata[7:0];
            REG_TRAILER: trailer_ff <= csr_pwdata[7:0];
            default:     header_ff  <= header_ff;
         endcase
      end
   end

   // Byte window.
   assign req_stall = busy_ff && (count_ff >= COUNT_PRE_END);
   assign req_take  = req_valid && !req_stall;

   for (genvar i = 0; i < WINDOW_CELLS; i++) begin : g_cell
      rfsc_byte_cell u_cell (
         .clock    (clock),
         .shift_en (req_take),
         .byte_in  ((i == WINDOW_CELLS - 1) ? req_rx_byte : win_byte[(i + 1) % WINDOW_CELLS]),
         .byte_out (win_byte[i])
      );
   end

   assign frame_match = req_take && (count_ff >= COUNT_PRE_END)
                        && (win_byte[0] == header_ff) && (req_rx_byte == trailer_ff);

   always_comb begin
      count_in = count_ff;
      if (frame_match) begin
         count_in = '0;
      end else if (req_take && (count_ff < COUNT_FULL)) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Channel queue.
   assign advance       = !rsp_valid_ff || !rsp_stall;
   assign push          = advance && busy_ff;
   assign push_tag.index = emit_idx_ff;
   assign push_tag.last  = (emit_idx_ff == 4'(CHANNELS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         emit_idx_ff <= '0;
      end else if (frame_match) begin
         busy_ff     <= 1'b1;
         emit_idx_ff <= '0;
      end else if (push) begin
         busy_ff     <= !push_tag.last;
         emit_idx_ff <= emit_idx_ff + 4'd1;
      end
   end

   for (genvar k = 0; k < CHANNELS; k++) begin : g_chan
      always_ff @(posedge clock) begin
         if (frame_match) begin
            chan_ff[k] <= {win_byte[1 + 2 * k], win_byte[2 + 2 * k]};
         end else if (push) begin
            chan_ff[k] <= chan_ff[(k + 1) % CHANNELS];
         end
      end
   end

   rfsc_scaler u_scaler (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (push),
      .in_raw    (chan_ff[0]),
      .in_tag    (push_tag),
      .out_valid (sc_valid),
      .out_neg   (sc_neg),
      .out_quot  (sc_quot),
      .out_tag   (sc_tag)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sc_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_index_ff <= sc_tag.index;
         rsp_last_ff  <= sc_tag.last;
         rsp_value_ff <= sc_neg ? -$signed(sc_quot) : $signed(sc_quot);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel_index = rsp_index_ff;
   assign rsp_channel_value = rsp_value_ff;
   assign rsp_last_channel  = rsp_last_ff;

endmodule

@@ design/rfsc_byte_cell.sv @@
// ----------------------------------------------------------------------------
// rfsc_byte_cell
// One byte of the receive window; takes its neighbor's byte on each shift.
// ----------------------------------------------------------------------------
module rfsc_byte_cell (
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] byte_in,
   output logic [7:0] byte_out
);

   logic [7:0] byte_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

endmodule

@@ design/rfsc_scaler.sv @@
// ----------------------------------------------------------------------------
// rfsc_scaler
// Two-stage pipeline that centers and scales one raw channel value.
// ----------------------------------------------------------------------------
module rfsc_scaler (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [15:0]           in_raw,
   input  rfsc_pkg::rfsc_tag_type in_tag,
   output logic                  out_valid,
   output logic                  out_neg,
   output logic [13:0]           out_quot,
   output rfsc_pkg::rfsc_tag_type out_tag
);
   import rfsc_pkg::*;

   logic signed [17:0] diff;
   logic [16:0]        abs_diff;
   logic [18:0]        mag_in;
   logic [38:0]        prod;

   logic               s1_valid_ff;
   logic               s1_neg_ff;
   logic [18:0]        s1_mag_ff;
   rfsc_tag_type       s1_tag_ff;

   logic               s2_valid_ff;
   logic               s2_neg_ff;
   logic [13:0]        s2_quot_ff;
   rfsc_tag_type       s2_tag_ff;

   always_comb begin
      diff     = $signed({2'b00, in_raw}) - RAW_CENTER;
      abs_diff = diff[17] ? 17'(-diff) : 17'(diff);
      mag_in   = {abs_diff, 2'b00} + 19'(abs_diff);
      prod     = 39'(s1_mag_ff) * 39'(RECIP_MUL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_neg_ff  <= diff[17];
         s1_mag_ff  <= mag_in;
         s1_tag_ff  <= in_tag;
         s2_neg_ff  <= s1_neg_ff;
         s2_quot_ff <= prod[RECIP_SHIFT +: 14];
         s2_tag_ff  <= s1_tag_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_neg   = s2_neg_ff;
   assign out_quot  = s2_quot_ff;
   assign out_tag   = s2_tag_ff;

endmodule

@@ design/rfsc_checker.sv @@
// ----------------------------------------------------------------------------
// rfsc_checker
// Port-level checks of the channel decoder, bound to its top level.
// ----------------------------------------------------------------------------
module rfsc_checker #(
   parameter int CHANNELS = 16
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [7:0]                      req_rx_byte,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [3:0]                      rsp_channel_index,
   input logic signed [13:0]              rsp_channel_value,
   input logic                            rsp_last_channel,
   input logic                            csr_psel,
   input logic                            csr_penable,
   input logic                            csr_pwrite,
   input logic [rfsc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [rfsc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic [rfsc_pkg::CSR_DATA_W-1:0] csr_prdata,
   input logic                            csr_pready
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_channel_index)
      && $stable(rsp_channel_value) && $stable(rsp_last_channel))
      else $error("Stalled result transfer changed.");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_channel_value >= -14'sd120) && (rsp_channel_value <= 14'sd7871))
      else $error("Channel value out of range.");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_channel == (rsp_channel_index == 4'(CHANNELS - 1))))
      else $error("Last flag does not match the final channel.");

   a_next_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_channel ##1 rsp_valid
      |-> (rsp_channel_index == $past(rsp_channel_index) + 4'd1))
      else $error("Channel index did not advance within a frame.");

endmodule

bind remote_frame_sync_channel_decode_unit rfsc_checker #(.CHANNELS(CHANNELS)) u_rfsc_checker (.*);
